// ----- sv/spq_pkg.sv -----
package spq_pkg;

	localparam int KEY_W        = 17;
	localparam int TAG_W        = 16;
	localparam int COUNT_W      = 10;
	localparam int CAPACITY_DEF = 512;

	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_REMOVE = 1'b1;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [TAG_W-1:0] tag;
	} spq_entry_t;

	// Broadcast to every cell in the chain for the operation taking effect this cycle.
	typedef struct packed {
		logic       ins;
		logic       rem;
		spq_entry_t entry;
	} spq_ctrl_t;

endpackage

// ----- sv/spq_if.sv -----
interface spq_req_if;
	logic                      valid;
	logic                      ready;
	logic                      kind;
	logic [spq_pkg::KEY_W-1:0] key_value;
	logic [spq_pkg::TAG_W-1:0] entry_tag;

	modport source (output valid, kind, key_value, entry_tag, input ready);
	modport sink (input valid, kind, key_value, entry_tag, output ready);
endinterface

interface spq_rsp_if;
	logic                        valid;
	logic                        ready;
	logic                        accepted;
	logic [spq_pkg::KEY_W-1:0]   removed_key;
	logic [spq_pkg::TAG_W-1:0]   removed_tag;
	logic [spq_pkg::COUNT_W-1:0] entry_count;
	logic                        is_empty;
	logic                        is_full;

	modport source (output valid, accepted, removed_key, removed_tag, entry_count,
		is_empty, is_full, input ready);
	modport sink (input valid, accepted, removed_key, removed_tag, entry_count,
		is_empty, is_full, output ready);
endinterface

// ----- sv/spq_cell.sv -----
module spq_cell (
	input  logic                clk,
	input  spq_pkg::spq_ctrl_t  ctrl,
	input  logic                occupied,
	input  logic                above_ge,
	input  spq_pkg::spq_entry_t above,
	input  spq_pkg::spq_entry_t below,
	output spq_pkg::spq_entry_t entry,
	output logic                ge
);

	spq_pkg::spq_entry_t entry_q;
	spq_pkg::spq_entry_t entry_d;

	// The chain is kept in descending order, so an occupied cell whose key is not
	// smaller than the new key stays put and the new entry lands just after it.
	assign ge    = occupied && (entry_q.key >= ctrl.entry.key);
	assign entry = entry_q;

	always_comb begin
		entry_d = entry_q;
		if (ctrl.rem) begin
			entry_d = below;
		end else if (ctrl.ins && !ge) begin
			if (above_ge) begin
				entry_d = ctrl.entry;
			end else begin
				entry_d = above;
			end
		end
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

endmodule

// ----- sv/sorted_priority_queue.sv -----
// Result: a result appears in the output register in the cycle after its request is taken.
// Throughput: one request per cycle; every cell of the chain compares and shifts in parallel,
// and the next request is taken while a result waits as long as the result is taken too.
// Reset: arst_n clears the entry count and the output valid; stored entries are left as they
// are and are never read before they are written.
module sorted_priority_queue #(
	parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
	input logic        clk,
	input logic        arst_n,
	spq_req_if.sink    request,
	spq_rsp_if.source  result
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    count_d;
	logic                fire;
	logic                do_ins;
	logic                do_rem;
	logic                rsp_valid_q;
	spq_pkg::spq_ctrl_t  ctrl;
	spq_pkg::spq_entry_t cell_entry [CAPACITY];
	logic                cell_ge    [CAPACITY];

	assign request.ready = !rsp_valid_q || result.ready;
	assign fire   = request.valid && request.ready;
	assign do_ins = fire && (request.kind == spq_pkg::KIND_INSERT)
		&& (count_q != CNT_W'(CAPACITY));
	assign do_rem = fire && (request.kind == spq_pkg::KIND_REMOVE) && (count_q != '0);

	assign ctrl.ins       = do_ins;
	assign ctrl.rem       = do_rem;
	assign ctrl.entry.key = request.key_value;
	assign ctrl.entry.tag = request.entry_tag;

	always_comb begin
		count_d = count_q;
		if (do_ins) begin
			count_d = count_q + CNT_W'(1);
		end else if (do_rem) begin
			count_d = count_q - CNT_W'(1);
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                occ;
		logic                above_ge;
		spq_pkg::spq_entry_t above;
		spq_pkg::spq_entry_t below;

		assign occ = count_q > CNT_W'(i);

		if (i == 0) begin : g_head
			assign above_ge = 1'b1;
			assign above    = cell_entry[i];
		end else begin : g_body
			assign above_ge = cell_ge[i-1];
			assign above    = cell_entry[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign below = cell_entry[i];
		end else begin : g_mid
			assign below = cell_entry[i+1];
		end

		spq_cell u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.occupied (occ),
			.above_ge (above_ge),
			.above    (above),
			.below    (below),
			.entry    (cell_entry[i]),
			.ge       (cell_ge[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (fire) begin
				rsp_valid_q <= 1'b1;
			end else if (result.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// The head cell always holds the largest key, so a remove reports it directly.
	always_ff @(posedge clk) begin
		if (fire) begin
			result.accepted    <= do_ins || do_rem;
			result.removed_key <= do_rem ? cell_entry[0].key : '0;
			result.removed_tag <= do_rem ? cell_entry[0].tag : '0;
			result.entry_count <= spq_pkg::COUNT_W'(count_d);
			result.is_empty    <= (count_d == '0);
			result.is_full     <= (count_d == CNT_W'(CAPACITY));
		end
	end

	assign result.valid = rsp_valid_q;

endmodule
